@@ rtl/mtd_pkg.sv @@
package mtd_pkg;

	// Geometry limits of the pyramid.
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_LEVELS   = 10;
	localparam int HEIGHT_LIMIT = 4096;

	// Register and field widths.
	localparam int CFG_W_BITS    = 11;
	localparam int CFG_H_BITS    = 13;
	localparam int CFG_L_BITS    = 4;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_IDX_BITS  = 2;
	localparam int COL_BITS      = 10;
	localparam int ROW_BITS      = 12;
	localparam int X_BITS        = COL_BITS - 1;
	localparam int Y_BITS        = ROW_BITS - 1;
	localparam int LVL_BITS      = 4;
	localparam int LVL_SLOTS     = MAX_LEVELS + 1;
	localparam int IDX_BITS      = $clog2(MAX_WIDTH);
	localparam int CHAN_BITS     = 8;
	localparam int PAIR_BITS     = CHAN_BITS + 1;
	localparam int TRIPLE_BITS   = CHAN_BITS + 2;
	localparam int ENTRY_BITS    = 3 * PAIR_BITS + CHAN_BITS;
	localparam int OUT_DEPTH     = 2;

	// Division by three as multiply by 683 and shift by 11; exact for sums up to 765.
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;

	// Register values after reset.
	localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 11'd1024;
	localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 13'd1024;
	localparam logic [CFG_L_BITS-1:0] RESET_LEVELS = 4'd10;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LEVELS = 2'd2
	} cfg_reg_t;

	// What a source pixel does at its level.
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_FIRST,
		ACT_ADD,
		ACT_RESULT
	} act_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] alpha;
	} pix_t;

	// Row store entry: pairwise RGB sums of top-left and right, plus top-left alpha.
	typedef struct packed {
		logic [PAIR_BITS-1:0] red;
		logic [PAIR_BITS-1:0] green;
		logic [PAIR_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] alpha;
	} entry_t;

	typedef struct packed {
		logic [LVL_BITS-1:0] level;
		logic [X_BITS-1:0]   col;
		logic [Y_BITS-1:0]   row;
		pix_t                pix;
		logic                last;
	} res_t;

	// Effective geometry derived from the registers.
	typedef struct packed {
		logic [CFG_W_BITS-1:0] w0;
		logic [CFG_H_BITS-1:0] h0;
		logic [LVL_BITS-1:0]   n;
	} geom_t;

	typedef struct packed {
		act_t                act;
		logic [COL_BITS-1:0] next_c;
		logic [ROW_BITS-1:0] next_r;
		logic [X_BITS-1:0]   x;
		logic [Y_BITS-1:0]   y;
		logic [IDX_BITS-1:0] idx;
	} step_t;

	// Advances the raster position of level k and classifies the pixel found there.
	function automatic step_t level_step(input logic [LVL_BITS-1:0] k,
			input logic [COL_BITS-1:0] c, input logic [ROW_BITS-1:0] r, input geom_t g);
		logic [CFG_W_BITS-1:0] w;
		logic [CFG_H_BITS-1:0] h;
		logic [CFG_W_BITS-1:0] w_even;
		logic [CFG_H_BITS-1:0] h_even;
		logic [IDX_BITS:0]     base;
		logic [IDX_BITS:0]     idx_full;
		step_t                 s;
		w        = g.w0 >> k;
		h        = g.h0 >> k;
		w_even   = {w[CFG_W_BITS-1:1], 1'b0};
		h_even   = {h[CFG_H_BITS-1:1], 1'b0};
		base     = (IDX_BITS+1)'(MAX_WIDTH)
			- ((((IDX_BITS+1)'(MAX_WIDTH)) >> (k + 1'b1)) << 1);
		idx_full = base + (IDX_BITS+1)'(c[COL_BITS-1:1]);
		s        = '0;
		s.act    = ACT_NONE;
		if (CFG_W_BITS'(c) + CFG_W_BITS'(1) >= w) begin
			s.next_c = '0;
			s.next_r = (CFG_H_BITS'(r) + CFG_H_BITS'(1) >= h) ? '0 : r + 1'b1;
		end else begin
			s.next_c = c + 1'b1;
			s.next_r = r;
		end
		s.x   = c[COL_BITS-1:1];
		s.y   = r[ROW_BITS-1:1];
		s.idx = idx_full[IDX_BITS-1:0];
		if (k < g.n && CFG_W_BITS'(c) < w_even && CFG_H_BITS'(r) < h_even
				&& idx_full < (IDX_BITS+1)'(MAX_WIDTH)) begin
			if (!r[0]) begin
				s.act = c[0] ? ACT_ADD : ACT_FIRST;
			end else if (!c[0]) begin
				s.act = ACT_RESULT;
			end
		end
		return s;
	endfunction

	function automatic logic [CHAN_BITS-1:0] div3(input logic [TRIPLE_BITS-1:0] s);
		logic [TRIPLE_BITS+DIV3_SHIFT-1:0] p;
		p = (TRIPLE_BITS+DIV3_SHIFT)'(s) * (TRIPLE_BITS+DIV3_SHIFT)'(DIV3_MUL);
		return p[DIV3_SHIFT +: CHAN_BITS];
	endfunction

endpackage

@@ rtl/mtd_ifs.sv @@
interface mtd_pix_if;
	import mtd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CHAN_BITS-1:0] red;
	logic [CHAN_BITS-1:0] green;
	logic [CHAN_BITS-1:0] blue;
	logic [CHAN_BITS-1:0] alpha;
	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface mtd_res_if;
	import mtd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [LVL_BITS-1:0]  level;
	logic [X_BITS-1:0]    col;
	logic [Y_BITS-1:0]    row;
	logic [CHAN_BITS-1:0] out_red;
	logic [CHAN_BITS-1:0] out_green;
	logic [CHAN_BITS-1:0] out_blue;
	logic [CHAN_BITS-1:0] out_alpha;
	logic                 last_of_run;
	modport source (output valid, level, col, row, out_red, out_green, out_blue, out_alpha,
		last_of_run, input ready);
	modport sink (input valid, level, col, row, out_red, out_green, out_blue, out_alpha,
		last_of_run, output ready);
endinterface

@@ rtl/mtd_row_ram.sv @@
module mtd_row_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 35
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/mtd_cfg.sv @@
module mtd_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  logic [mtd_pkg::CFG_IDX_BITS-1:0]   index,
	input  logic [mtd_pkg::CFG_DATA_BITS-1:0]  data,
	output mtd_pkg::geom_t                     geom,
	output logic                               clear
);
	import mtd_pkg::*;

	logic [CFG_W_BITS-1:0] width_q;
	logic [CFG_H_BITS-1:0] height_q;
	logic [CFG_L_BITS-1:0] levels_q;
	geom_t                 geom_q;

	// Clamps the registers and counts the levels that exist below the base.
	function automatic geom_t derive(input logic [CFG_W_BITS-1:0] w,
			input logic [CFG_H_BITS-1:0] h, input logic [CFG_L_BITS-1:0] l);
		geom_t               g;
		logic [LVL_BITS-1:0] lim;
		if (w == '0) begin
			g.w0 = CFG_W_BITS'(1);
		end else if (w > CFG_W_BITS'(MAX_WIDTH)) begin
			g.w0 = CFG_W_BITS'(MAX_WIDTH);
		end else begin
			g.w0 = w;
		end
		if (h == '0) begin
			g.h0 = CFG_H_BITS'(1);
		end else if (h > CFG_H_BITS'(HEIGHT_LIMIT)) begin
			g.h0 = CFG_H_BITS'(HEIGHT_LIMIT);
		end else begin
			g.h0 = h;
		end
		lim = (l > LVL_BITS'(MAX_LEVELS)) ? LVL_BITS'(MAX_LEVELS) : LVL_BITS'(l);
		g.n = '0;
		for (int j = 0; j < MAX_LEVELS; j++) begin
			if (LVL_BITS'(j) < lim && (g.w0 >> j) > CFG_W_BITS'(1)
					&& (g.h0 >> j) > CFG_H_BITS'(1)) begin
				g.n = g.n + 1'b1;
			end
		end
		return g;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			levels_q <= RESET_LEVELS;
			geom_q   <= derive(RESET_WIDTH, RESET_HEIGHT, RESET_LEVELS);
		end else begin
			if (we) begin
				case (index)
					REG_WIDTH:  width_q  <= data[CFG_W_BITS-1:0];
					REG_HEIGHT: height_q <= data[CFG_H_BITS-1:0];
					REG_LEVELS: levels_q <= data[CFG_L_BITS-1:0];
					default: ;
				endcase
			end
			geom_q <= derive(width_q, height_q, levels_q);
		end
	end

	// Any write to a defined register restarts the frame.
	assign clear = we && (index == REG_WIDTH || index == REG_HEIGHT || index == REG_LEVELS);
	assign geom  = geom_q;
endmodule

@@ rtl/mtd_out_fifo.sv @@
module mtd_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mtd_pkg::res_t din,
	output logic          full,
	mtd_res_if.source     res
);
	import mtd_pkg::*;

	localparam int PTR_BITS = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

	res_t                mem_q [OUT_DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                pop;
	res_t                head;

	assign pop  = res.valid && res.ready;
	assign full = (cnt_q == CNT_BITS'(OUT_DEPTH));
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	assign res.valid       = (cnt_q != '0);
	assign res.level       = head.level;
	assign res.col         = head.col;
	assign res.row         = head.row;
	assign res.out_red     = head.pix.red;
	assign res.out_green   = head.pix.green;
	assign res.out_blue    = head.pix.blue;
	assign res.out_alpha   = head.pix.alpha;
	assign res.last_of_run = head.last;
endmodule

@@ rtl/mipmap_three_tap_downsampler.sv @@
// Streaming mip pyramid builder with a three-tap box filter.
// Base RGBA8 pixels enter in raster order on the pix channel, one per transfer. Every
// destination pixel that an input completes leaves on the res channel with its level,
// column and row; the results of one input come in increasing level order and the final
// one carries last_of_run. Each result is also fed back as a source pixel of the next level.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data): width, height and
// level count. Writing any of them restarts the frame at the top-left pixel; write only
// while no input is in flight.
// Throughput: an input that completes no result does not hold off the next transfer. An
// input that completes results holds off the next one until its last result is fed back,
// because every level costs one pass through the two-stage read-modify-write loop around
// the row store, and each result re-enters that loop before the next pixel may.
// Reset puts the registers at 1024 x 1024 with ten levels and all raster counters at zero.
// The row store is not cleared; every entry is written before its contents are used.
// A two-entry output buffer decouples the receiver. When it is full a finished result waits
// in a holding register and the level loop and the input stall until space frees up.
module mipmap_three_tap_downsampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mtd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mtd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	mtd_pix_if.sink                           pix,
	mtd_res_if.source                         res
);
	import mtd_pkg::*;

	// Configuration and derived geometry.
	geom_t geom;
	logic  cfg_clear;

	mtd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.geom   (geom),
		.clear  (cfg_clear)
	);

	// Raster position of the next source pixel of each level.
	logic [COL_BITS-1:0] col_cnt_q [LVL_SLOTS];
	logic [ROW_BITS-1:0] row_cnt_q [LVL_SLOTS];

	// Stage one: a source pixel at some level, from the input or fed back from stage two.
	logic                valid_s1;
	logic [LVL_BITS-1:0] lvl_s1;
	pix_t                pix_s1;

	// Stage two: the row store read data is back and the entry is updated or consumed.
	logic                valid_s2;
	act_t                act_s2;
	logic [LVL_BITS-1:0] lvl_s2;
	logic [X_BITS-1:0]   x_s2;
	logic [Y_BITS-1:0]   y_s2;
	logic [IDX_BITS-1:0] idx_s2;
	pix_t                pix_s2;

	// A finished result waits here until the next level has decided whether it follows.
	logic                hold_valid_q;
	res_t                hold_q;

	// Write of the previous cycle, which the read issued in that cycle did not see.
	logic                fwd_valid_q;
	logic [IDX_BITS-1:0] fwd_idx_q;
	entry_t              fwd_data_q;

	step_t                  d1;
	logic                   s1_adv;
	logic                   s2_result;
	logic                   in_ready;
	logic                   in_take;
	logic                   fifo_full;
	logic                   fifo_push;
	res_t                   push_res;
	logic [ENTRY_BITS-1:0]  ram_rdata;
	entry_t                 ent;
	entry_t                 ram_wdata;
	logic                   ram_we;
	logic [TRIPLE_BITS-1:0] sum_red;
	logic [TRIPLE_BITS-1:0] sum_green;
	logic [TRIPLE_BITS-1:0] sum_blue;
	pix_t                   mean_pix;
	res_t                   res_new;

	assign d1 = level_step(lvl_s1, col_cnt_q[lvl_s1], row_cnt_q[lvl_s1], geom);

	// A pixel whose held predecessor cannot reach the output buffer must wait, because
	// its own decision sets that predecessor's last flag.
	assign s1_adv    = valid_s1 && !(hold_valid_q && fifo_full);
	assign s2_result = valid_s2 && (act_s2 == ACT_RESULT);

	// A new input may not overtake the feedback of a result still on its way.
	assign in_ready = (!valid_s1 || s1_adv) && !(valid_s1 && d1.act == ACT_RESULT)
		&& !s2_result;
	assign pix.ready = in_ready;
	assign in_take   = pix.valid && in_ready;

	mtd_row_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (ENTRY_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s2),
		.wdata (ram_wdata),
		.re    (s1_adv),
		.raddr (d1.idx),
		.rdata (ram_rdata)
	);

	assign ent = (fwd_valid_q && fwd_idx_q == idx_s2) ? fwd_data_q : entry_t'(ram_rdata);

	assign sum_red   = TRIPLE_BITS'(ent.red) + TRIPLE_BITS'(pix_s2.red);
	assign sum_green = TRIPLE_BITS'(ent.green) + TRIPLE_BITS'(pix_s2.green);
	assign sum_blue  = TRIPLE_BITS'(ent.blue) + TRIPLE_BITS'(pix_s2.blue);

	always_comb begin
		mean_pix.red   = div3(sum_red);
		mean_pix.green = div3(sum_green);
		mean_pix.blue  = div3(sum_blue);
		mean_pix.alpha = ent.alpha;
		res_new.level  = lvl_s2 + 1'b1;
		res_new.col    = x_s2;
		res_new.row    = y_s2;
		res_new.pix    = mean_pix;
		res_new.last   = 1'b0;
	end

	// Top row of a block: the left pixel starts the entry, the right one adds to it.
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = ent;
		case (act_s2)
			ACT_FIRST: begin
				ram_we          = valid_s2;
				ram_wdata.red   = PAIR_BITS'(pix_s2.red);
				ram_wdata.green = PAIR_BITS'(pix_s2.green);
				ram_wdata.blue  = PAIR_BITS'(pix_s2.blue);
				ram_wdata.alpha = pix_s2.alpha;
			end
			ACT_ADD: begin
				ram_we          = valid_s2;
				ram_wdata.red   = ent.red + PAIR_BITS'(pix_s2.red);
				ram_wdata.green = ent.green + PAIR_BITS'(pix_s2.green);
				ram_wdata.blue  = ent.blue + PAIR_BITS'(pix_s2.blue);
				ram_wdata.alpha = ent.alpha;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// The held result is the last of its run unless the next level completes another one.
	assign fifo_push = hold_valid_q && s1_adv;
	always_comb begin
		push_res      = hold_q;
		push_res.last = (d1.act != ACT_RESULT);
	end

	mtd_out_fifo u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.din    (push_res),
		.full   (fifo_full),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			hold_valid_q <= 1'b0;
			fwd_valid_q  <= 1'b0;
			for (int i = 0; i < LVL_SLOTS; i++) begin
				col_cnt_q[i] <= '0;
				row_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_clear) begin
				for (int i = 0; i < LVL_SLOTS; i++) begin
					col_cnt_q[i] <= '0;
					row_cnt_q[i] <= '0;
				end
			end else if (s1_adv) begin
				col_cnt_q[lvl_s1] <= d1.next_c;
				row_cnt_q[lvl_s1] <= d1.next_r;
			end
			if (s2_result || in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			valid_s2 <= s1_adv && (d1.act != ACT_NONE);
			if (s2_result) begin
				hold_valid_q <= 1'b1;
			end else if (fifo_push) begin
				hold_valid_q <= 1'b0;
			end
			fwd_valid_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_result) begin
			lvl_s1 <= lvl_s2 + 1'b1;
			pix_s1 <= mean_pix;
		end else if (in_take) begin
			lvl_s1       <= '0;
			pix_s1.red   <= pix.red;
			pix_s1.green <= pix.green;
			pix_s1.blue  <= pix.blue;
			pix_s1.alpha <= pix.alpha;
		end
		if (s1_adv) begin
			act_s2 <= d1.act;
			lvl_s2 <= lvl_s1;
			x_s2   <= d1.x;
			y_s2   <= d1.y;
			idx_s2 <= d1.idx;
			pix_s2 <= pix_s1;
		end
		if (s2_result) begin
			hold_q <= res_new;
		end
		fwd_idx_q  <= idx_s2;
		fwd_data_q <= ram_wdata;
	end

	// A held result always has its next-level pixel waiting in stage one.
	a_hold_has_token: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> valid_s1)
		else $error("held result without its next-level pixel");

	// A result re-enters stage one at the following level in the next cycle.
	a_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		s2_result |=> (valid_s1 && lvl_s1 == $past(lvl_s2) + 1'b1))
		else $error("result not fed back to the next level");

	// The holding register has been emptied before the next result arrives.
	a_hold_free: assert property (@(posedge clk) disable iff (!arst_n)
		s2_result |-> !hold_valid_q)
		else $error("result would overwrite a held result");

	// Results only come from levels that feed an existing level below.
	a_result_level: assert property (@(posedge clk) disable iff (!arst_n)
		s2_result |-> (lvl_s2 < geom.n))
		else $error("result from a level beyond the configured depth");
endmodule

@@ tb/mipmap_three_tap_downsampler_test.sv @@
module mipmap_three_tap_downsampler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mtd_pkg::*;

	// Index 3 has no register behind it; a write there must leave the frame untouched.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

	// Cycles allowed after the last expected result before the block counts as idle.
	localparam int unsigned SETTLE_CYCLES = 4 * MAX_LEVELS + 8;
	localparam int unsigned RANDOM_ITEMS  = 140;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;

	// Receiver back-pressure patterns, chosen by the upper bits of a free-running count.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_MOSTLY
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	mtd_pix_if pix_ch ();
	mtd_res_if res_ch ();

	mipmap_three_tap_downsampler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pixels waiting to be offered on the input channel, and the pyramid results that
	// the accepted pixels are known to produce, oldest first.
	pix_t pixel_queue[$];
	res_t pyramid_expect[$];

	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	bit [31:0] rx_tick = '0;
	int unsigned watch_cycles;

	// Shadow copy of the block: the three registers, the pairwise row sums of every level,
	// and the raster position of the next source pixel at each level.
	logic [CFG_W_BITS-1:0] geo_width  = RESET_WIDTH;
	logic [CFG_H_BITS-1:0] geo_height = RESET_HEIGHT;
	logic [CFG_L_BITS-1:0] geo_levels = RESET_LEVELS;
	entry_t pair_store [MAX_WIDTH];
	int unsigned src_col [LVL_SLOTS];
	int unsigned src_row [LVL_SLOTS];

	// Runs one base pixel through the cascade. Each level first advances its raster
	// position, then either starts a row pair (top-left), adds the right neighbor, or,
	// on the pixel below a stored pair, completes a destination pixel that is queued as
	// a result and handed down as the source pixel of the next level.
	function automatic void predict_pyramid(input pix_t p);
		int unsigned w0, h0, lim, n, k, w, h, c, r, x, y, idx;
		int unsigned pr, pg, pb, pa, produced;
		res_t item;
		w0 = (geo_width == 0) ? 1 : (geo_width > MAX_WIDTH) ? MAX_WIDTH : geo_width;
		h0 = (geo_height == 0) ? 1 : (geo_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : geo_height;
		lim = (geo_levels > MAX_LEVELS) ? MAX_LEVELS : geo_levels;
		pr = p.red;
		pg = p.green;
		pb = p.blue;
		pa = p.alpha;
		produced = 0;
		n = 0;
		while (n < lim && (w0 >> n) > 1 && (h0 >> n) > 1)
			n++;
		for (k = 0; k <= MAX_LEVELS; k++) begin
			w = w0 >> k;
			h = h0 >> k;
			c = src_col[k];
			r = src_row[k];
			// The raster position moves on even for levels that produce nothing.
			if (c + 1 >= w) begin
				src_col[k] = 0;
				src_row[k] = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				src_col[k] = c + 1;
			end
			if (k >= n)
				break;
			// The last column or row of an odd-sized level is consumed and dropped.
			if (c >= 2 * (w >> 1) || r >= 2 * (h >> 1))
				break;
			x = c >> 1;
			y = r >> 1;
			idx = MAX_WIDTH - 2 * (MAX_WIDTH >> (k + 1)) + x;
			if (idx >= MAX_WIDTH)
				break;
			if ((r & 1) == 0) begin
				if ((c & 1) == 0) begin
					pair_store[idx] = {9'(pr), 9'(pg), 9'(pb), 8'(pa)};
				end else begin
					pair_store[idx].red   = pair_store[idx].red + 9'(pr);
					pair_store[idx].green = pair_store[idx].green + 9'(pg);
					pair_store[idx].blue  = pair_store[idx].blue + 9'(pb);
				end
				break;
			end
			if ((c & 1) != 0)
				break;
			pr = (pair_store[idx].red + pr) / 3;
			pg = (pair_store[idx].green + pg) / 3;
			pb = (pair_store[idx].blue + pb) / 3;
			pa = pair_store[idx].alpha;
			item.level     = LVL_BITS'(k + 1);
			item.col       = X_BITS'(x);
			item.row       = Y_BITS'(y);
			item.pix.red   = 8'(pr);
			item.pix.green = 8'(pg);
			item.pix.blue  = 8'(pb);
			item.pix.alpha = 8'(pa);
			item.last      = 1'b0;
			pyramid_expect.push_back(item);
			produced++;
		end
		// Only the deepest result of the run carries the end marker.
		if (produced > 0) begin
			item = pyramid_expect.pop_back();
			item.last = 1'b1;
			pyramid_expect.push_back(item);
		end
	endfunction

	function automatic pix_t random_pixel();
		pix_t p;
		p = $urandom;
		// Now and then a pixel saturated in every channel, to push the sums to their ends.
		if ($urandom_range(0, 9) == 0)
			p = $urandom_range(0, 1) ? '1 : '0;
		return p;
	endfunction

	// Input driver. It works in bursts of random length separated by random gaps, and a
	// pixel stays on the channel unchanged until its transfer. The accepted pixel is
	// predicted at the edge of its transfer.
	always @(posedge clk or negedge arst_n) begin
		pix_t held;
		pix_t nxt;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			pix_ch.red   <= '0;
			pix_ch.green <= '0;
			pix_ch.blue  <= '0;
			pix_ch.alpha <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				held = {pix_ch.red, pix_ch.green, pix_ch.blue, pix_ch.alpha};
				predict_pyramid(held);
			end
			if (!pix_ch.valid || pix_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_ch.valid <= 1'b0;
				end else if (pixel_queue.size() != 0) begin
					nxt = pixel_queue.pop_front();
					pix_ch.valid <= 1'b1;
					pix_ch.red   <= nxt.red;
					pix_ch.green <= nxt.green;
					pix_ch.blue  <= nxt.blue;
					pix_ch.alpha <= nxt.alpha;
					// A third of the bursts run straight into the next one with no gap.
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left--;
					end
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every transfer on the result channel is checked against the oldest
	// expectation. Ready follows a pattern chosen by the upper tick bits: wide open, coin
	// flips, a long periodic stall, and mostly ready with short holes.
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_tick = '0;
		end else begin
			rx_tick++;
			if (res_ch.valid && res_ch.ready) begin
				got.level     = res_ch.level;
				got.col       = res_ch.col;
				got.row       = res_ch.row;
				got.pix.red   = res_ch.out_red;
				got.pix.green = res_ch.out_green;
				got.pix.blue  = res_ch.out_blue;
				got.pix.alpha = res_ch.out_alpha;
				got.last      = res_ch.last_of_run;
				if (pyramid_expect.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: level %0d (%0d,%0d) rgba %h last %b",
							got.level, got.col, got.row, got.pix, got.last);
				end else begin
					want = pyramid_expect.pop_front();
					if (got.level !== want.level || got.col !== want.col
							|| got.row !== want.row || got.pix.red !== want.pix.red
							|| got.pix.green !== want.pix.green
							|| got.pix.blue !== want.pix.blue
							|| got.pix.alpha !== want.pix.alpha || got.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: got level %0d (%0d,%0d) rgba %h last %b, %s %0d (%0d,%0d) rgba %h last %b",
								got.level, got.col, got.row, got.pix, got.last,
								"wanted level", want.level, want.col, want.row,
								want.pix, want.last);
					end
				end
			end
			case (rx_mode_t'(rx_tick[7:6]))
				RX_OPEN: begin
					res_ch.ready <= 1'b1;
				end
				RX_COIN: begin
					res_ch.ready <= 1'($urandom_range(0, 1));
				end
				RX_PERIODIC: begin
					res_ch.ready <= (rx_tick[2:0] == 3'd0);
				end
				default: begin
					res_ch.ready <= ($urandom_range(0, 4) != 0);
				end
			endcase
		end
	end

	// Drives one register write; the write takes effect at the next rising edge. Write
	// enable is left high so that writes can follow back to back; the caller lowers it.
	// Any mapped register restarts the frame at every level, the unmapped index does not.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		bit mapped;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		mapped = 1'b1;
		case (idx)
			REG_WIDTH:  geo_width  = val[CFG_W_BITS-1:0];
			REG_HEIGHT: geo_height = val[CFG_H_BITS-1:0];
			REG_LEVELS: geo_levels = val[CFG_L_BITS-1:0];
			default:    mapped = 1'b0;
		endcase
		if (mapped) begin
			foreach (src_col[i]) begin
				src_col[i] = 0;
				src_row[i] = 0;
			end
		end
	endtask

	task automatic configure(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
			input logic [CFG_DATA_BITS-1:0] lv);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_LEVELS, lv);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pixels are queued on the falling edge so the driver never races the queue.
	task automatic feed_random(input int unsigned count);
		@(negedge clk);
		repeat (count) pixel_queue.push_back(random_pixel());
	endtask

	// Waits until every queued pixel has been transferred and every expected result has
	// come back, then lets the block finish any input that produces nothing.
	task automatic wait_drained();
		while (pixel_queue.size() != 0 || pix_ch.valid || pyramid_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One setting of the registers and a stream of random pixels. With a nonzero pause
	// point the sender stops there until the block has emptied completely.
	task automatic run_phase(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
			input logic [CFG_DATA_BITS-1:0] lv, input int unsigned count,
			input int unsigned pause_at);
		configure(w, h, lv);
		if (pause_at != 0 && pause_at < count) begin
			feed_random(pause_at);
			wait_drained();
			feed_random(count - pause_at);
		end else begin
			feed_random(count);
		end
		wait_drained();
	endtask

	initial begin : watchdog
		for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned w, h, lv, area, count, pause_at, fed, round;
		pix_t p;
		pix_ch.valid = 1'b0;
		pix_ch.red   = '0;
		pix_ch.green = '0;
		pix_ch.blue  = '0;
		pix_ch.alpha = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Odd 3 x 5 frame with an out-of-range level count: the right column and the bottom
		// row are dropped, and two extra pixels wrap into the next frame. Pixels cycle
		// through full white, full black and a mixed pattern, plus random ones. After the seventh
		// pixel the sender stops until the block is empty and the unmapped index is written,
		// which must not restart the frame.
		configure(3, 5, 15);
		@(negedge clk);
		for (int i = 0; i < 17; i++) begin
			case (i % 4)
				0:       p = '1;
				1:       p = '0;
				2:       p = {8'hAA, 8'h55, 8'hFF, 8'h01};
				default: p = random_pixel();
			endcase
			pixel_queue.push_back(p);
			if (i == 6) begin
				wait_drained();
				write_reg(REG_UNMAPPED, '1);
				@(posedge clk);
				cfg_we <= 1'b0;
				@(negedge clk);
			end
		end
		wait_drained();

		// Zero in every register: a 1 x 1 image with no levels produces nothing.
		run_phase(0, 0, 0, 3, 0);

		// Smallest pyramid: one 2 x 2 block at full scale, so the three-tap sum reaches its
		// maximum, and the bottom-right pixel is ignored. Alpha comes from the top-left.
		configure(2, 2, 1);
		@(negedge clk);
		pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'h80});
		pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF});
		pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'h00});
		pixel_queue.push_back({8'h00, 8'h00, 8'h00, 8'h00});
		wait_drained();

		// Random small frames, odd and even, with level counts that sometimes go past the
		// limit or to zero. Most phases run whole frames and wrap into the next; some stop
		// mid-frame so the register write of the next phase cuts the frame short.
		fed = 0;
		round = 0;
		while (fed < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 8);
			h = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 8);
			lv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
			area = w * h;
			count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area)
				: area + $urandom_range(0, area);
			if (count > RANDOM_ITEMS - fed)
				count = RANDOM_ITEMS - fed;
			pause_at = (round == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, count) : 0;
			run_phase(CFG_DATA_BITS'(w), CFG_DATA_BITS'(h), CFG_DATA_BITS'(lv), count,
				pause_at);
			fed += count;
			round++;
		end

		// Extremes of the registers. A width above the maximum acts as the full line width;
		// only the start of the first row is sent.
		run_phase(2047, 2, 15, 24, 0);
		// Tallest images, exact and clamped, only the top rows.
		run_phase(2, CFG_DATA_BITS'(HEIGHT_LIMIT), CFG_DATA_BITS'(MAX_LEVELS), 24, 0);
		run_phase(2, 8191, 1, 24, 0);
		// An 8 x 8 frame reaches three levels deep and then wraps.
		run_phase(8, 8, CFG_DATA_BITS'(MAX_LEVELS), 8 * 8 + 8, 0);

		wait_drained();
		if (mismatch_count == 0 && pyramid_expect.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
